// ===== rtl/btnlp_pkg.sv =====
// ----------------------------------------------------------------------------
// btnlp_pkg: shared types and constants
// Event codes, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package btnlp_pkg;

   // field widths
   localparam int TimeWidth     = 32;
   localparam int DelayWidth    = 16;
   localparam int CountWidth    = 16;
   localparam int EventWidth    = 2;
   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 16;

   // divider sizing
   localparam int DivSteps    = TimeWidth;
   localparam int DivCntWidth = $clog2(DivSteps);

   // reset values of the configuration registers
   localparam logic [DelayWidth-1:0] LongPressReset = 16'd500;
   localparam logic [DelayWidth-1:0] RepeatReset    = 16'd250;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] RegLongPress = 8'd0;
   localparam logic [CsrIndexWidth-1:0] RegRepeat    = 8'd1;

   // event codes
   typedef enum logic [EventWidth-1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_LONG   = 2'd2,
      EV_REPEAT = 2'd3
   } event_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DECIDE = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_COMMIT = 2'd3
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic div_start;
      logic div_step;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

endpackage

// ===== rtl/btnlp_if.sv =====
// ----------------------------------------------------------------------------
// btnlp channel interfaces
// Valid/ready channels for key samples, events and register writes.
// ----------------------------------------------------------------------------

// key sample channel
interface btnlp_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   pressed;
   logic [btnlp_pkg::TimeWidth-1:0]        now_ms;

   modport source (output valid, output pressed, output now_ms, input ready);
   modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

// event channel
interface btnlp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [btnlp_pkg::EventWidth-1:0]       event_res;

   modport source (output valid, output event_res, input ready);
   modport sink   (input valid, input event_res, output ready);
endinterface

// register write channel
interface btnlp_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [btnlp_pkg::CsrIndexWidth-1:0]    index;
   logic [btnlp_pkg::CsrDataWidth-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/btnlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// btnlp_ctrl: sequencing controller
// Accepts an item, runs the repeat divider when the hold needs it, then
// commits the decision into the output register.
// ----------------------------------------------------------------------------
module btnlp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  btnlp_pkg::status_type  status,
   output btnlp_pkg::cmd_type     cmd
);

   btnlp_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   // output register can take a new item
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         btnlp_pkg::ST_IDLE: begin
            if (req_valid) state_in = btnlp_pkg::ST_DECIDE;
         end
         btnlp_pkg::ST_DECIDE: begin
            state_in = status.need_div ? btnlp_pkg::ST_DIVIDE : btnlp_pkg::ST_COMMIT;
         end
         btnlp_pkg::ST_DIVIDE: begin
            if (status.div_last) state_in = btnlp_pkg::ST_COMMIT;
         end
         btnlp_pkg::ST_COMMIT: begin
            if (out_free) state_in = btnlp_pkg::ST_IDLE;
         end
         default: state_in = btnlp_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         btnlp_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         btnlp_pkg::ST_DECIDE: begin
            cmd.div_start = status.need_div;
         end
         btnlp_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         btnlp_pkg::ST_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btnlp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/btnlp_datapath.sv =====
// ----------------------------------------------------------------------------
// btnlp_datapath: hold state, delay registers and repeat divider
// Keeps the press record, runs a restoring divide one quotient bit per
// cycle and forms the event on commit.
// ----------------------------------------------------------------------------
module btnlp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  btnlp_pkg::cmd_type                    cmd,
   output btnlp_pkg::status_type                 status,
   input  logic                                  req_pressed,
   input  logic [btnlp_pkg::TimeWidth-1:0]       req_now_ms,
   input  logic                                  cfg_we,
   input  logic [btnlp_pkg::CsrIndexWidth-1:0]   cfg_index,
   input  logic [btnlp_pkg::CsrDataWidth-1:0]    cfg_data,
   output logic [btnlp_pkg::EventWidth-1:0]      event_res
);

   localparam int TW = btnlp_pkg::TimeWidth;
   localparam int DW = btnlp_pkg::DelayWidth;
   localparam int CW = btnlp_pkg::CountWidth;

   // configuration
   logic [DW-1:0] long_ff, rep_ff;

   // captured item
   logic          key_ff;
   logic [TW-1:0] now_ff;

   // press record
   logic          holding_ff, holding_in;
   logic [TW-1:0] start_ff, start_in;
   logic [CW-1:0] fire_ff, fire_in;

   // divider
   logic [DW-1:0]                     rem_ff, rem_in;
   logic [TW-1:0]                     quo_ff, quo_in;
   logic [btnlp_pkg::DivCntWidth-1:0] cnt_ff, cnt_in;
   logic [DW:0]                       rem_shift, rem_diff;
   logic                              rem_ge;
   logic [TW-1:0]                     since;

   // decision
   btnlp_pkg::event_type evt_ff, evt_in;
   logic [TW-1:0]        held;
   logic [CW-1:0]        expected;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff <= btnlp_pkg::LongPressReset;
         rep_ff  <= btnlp_pkg::RepeatReset;
      end else if (cfg_we) begin
         if (cfg_index == btnlp_pkg::RegLongPress) long_ff <= cfg_data[DW-1:0];
         if (cfg_index == btnlp_pkg::RegRepeat)    rep_ff  <= cfg_data[DW-1:0];
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff <= req_pressed;
         now_ff <= req_now_ms;
      end
   end

   assign status.need_div = key_ff && holding_ff && (fire_ff != '0);

   // restoring divide step, zero divisor yields an all-ones quotient
   assign since     = now_ff - (start_ff + {{(TW-DW){1'b0}}, long_ff});
   assign rem_shift = {rem_ff, quo_ff[TW-1]};
   assign rem_diff  = rem_shift - {1'b0, rep_ff};
   assign rem_ge    = rem_shift >= {1'b0, rep_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = since;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
         quo_in = {quo_ff[TW-2:0], rem_ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign status.div_last = (cnt_ff == btnlp_pkg::DivCntWidth'(btnlp_pkg::DivSteps - 1));

   // event decision and state update
   assign held     = now_ff - start_ff;
   assign expected = quo_ff[CW-1:0] + 1'b1;

   always_comb begin
      holding_in = holding_ff;
      start_in   = start_ff;
      fire_in    = fire_ff;
      evt_in     = btnlp_pkg::EV_NONE;
      if (!key_ff && !holding_ff) begin
         evt_in = btnlp_pkg::EV_NONE;
      end else if (key_ff && !holding_ff) begin
         // first press: record the start
         holding_in = 1'b1;
         start_in   = now_ff;
         fire_in    = '0;
      end else if (!key_ff) begin
         // release: click only when nothing fired
         holding_in = 1'b0;
         if (fire_ff == '0) evt_in = btnlp_pkg::EV_CLICK;
      end else if (fire_ff == '0) begin
         if (held >= {{(TW-DW){1'b0}}, long_ff}) begin
            fire_in = CW'(1);
            evt_in  = btnlp_pkg::EV_LONG;
         end
      end else if (fire_ff < expected) begin
         fire_in = fire_ff + 1'b1;
         evt_in  = btnlp_pkg::EV_REPEAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff <= 1'b0;
         start_ff   <= '0;
         fire_ff    <= '0;
      end else if (cmd.commit) begin
         holding_ff <= holding_in;
         start_ff   <= start_in;
         fire_ff    <= fire_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (cmd.commit) evt_ff <= evt_in;
   end

   assign event_res = evt_ff;

endmodule

// ===== rtl/button_click_longpress_repeat_unit.sv =====
// ----------------------------------------------------------------------------
// button_click_longpress_repeat_unit: key click, long press and auto repeat
// Turns timestamped key samples into click, long-press and repeat events.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  req_if   in   valid/ready   pressed, now_ms
//  rsp_if   out  valid/ready   event_res
//  csr_if   in   valid/ready   index, data (0 long press delay, 1 repeat delay)
//
// an item passes through the decide and commit states, and through the
// 32-step restoring divider as well while a held key is past its long press
// synchronous active-high reset restores the delays to 500 and 250 ms and
// clears the hold record; register writes are always taken
// a waiting event sits in the output register while the next item enters;
// the commit stalls only when that register is still full
//
module button_click_longpress_repeat_unit (
   input  logic            clock,
   input  logic            reset,
   btnlp_req_if.sink       req_if,
   btnlp_rsp_if.source     rsp_if,
   btnlp_csr_if.sink       csr_if
);

   btnlp_pkg::cmd_type    cmd;
   btnlp_pkg::status_type status;

   // register writes never stall
   assign csr_if.ready = 1'b1;

   btnlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   btnlp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_pressed (req_if.pressed),
      .req_now_ms  (req_if.now_ms),
      .cfg_we      (csr_if.valid),
      .cfg_index   (csr_if.index),
      .cfg_data    (csr_if.data),
      .event_res   (rsp_if.event_res)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: key click, long press and auto repeat unit testbench
// Drives timestamped key samples through the unit under several delay
// settings, predicts each event in step with the accepted samples and
// checks every event against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ClockHalf    = 4;
   localparam int ResetCycles  = 12;
   localparam int QuietLimit   = 2000;
   localparam int SettleCycles = 40;
   localparam int PhaseItems   = 175;
   localparam logic [btnlp_pkg::CsrIndexWidth-1:0] RegUnused = 8'd7;

   typedef struct packed {
      logic                            pressed;
      logic [btnlp_pkg::TimeWidth-1:0] now_ms;
   } key_sample_type;

   logic clock;
   logic reset;

   btnlp_req_if req_if ();
   btnlp_rsp_if rsp_if ();
   btnlp_csr_if csr_if ();

   button_click_longpress_repeat_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // pending samples and predicted events
   key_sample_type       sample_q[$];
   btnlp_pkg::event_type event_q[$];

   // predicted unit state and register copies
   logic                             key_held;
   logic [btnlp_pkg::TimeWidth-1:0]  hold_start_ms;
   logic [btnlp_pkg::CountWidth-1:0] fires;
   logic [btnlp_pkg::DelayWidth-1:0] long_ms;
   logic [btnlp_pkg::DelayWidth-1:0] rep_ms;

   // stimulus side view of the delays, used to size time steps
   int unsigned                     gen_long;
   int unsigned                     gen_rep;
   logic [btnlp_pkg::TimeWidth-1:0] tick_ms;
   int                              phase_count;

   int  err_count;
   int  quiet_cycles;
   bit  idle_on;
   bit  req_taken;
   int  req_gap;
   int  rsp_gap;

   // clock
   initial clock = 1'b0;
   always #ClockHalf clock = ~clock;

   // predict the event for one key sample and advance the hold record
   function automatic btnlp_pkg::event_type predict_event(
      input logic                            key,
      input logic [btnlp_pkg::TimeWidth-1:0] now);
      logic [btnlp_pkg::TimeWidth-1:0]  held;
      logic [btnlp_pkg::TimeWidth-1:0]  since;
      logic [btnlp_pkg::TimeWidth-1:0]  quot;
      logic [btnlp_pkg::TimeWidth-1:0]  total;
      logic [btnlp_pkg::CountWidth-1:0] want;
      if (!key && !key_held) return btnlp_pkg::EV_NONE;
      if (key && !key_held) begin
         key_held      = 1'b1;
         hold_start_ms = now;
         fires         = '0;
         return btnlp_pkg::EV_NONE;
      end
      if (!key) begin
         key_held = 1'b0;
         return (fires == '0) ? btnlp_pkg::EV_CLICK : btnlp_pkg::EV_NONE;
      end
      if (fires == '0) begin
         held = now - hold_start_ms;
         if (held >= {16'd0, long_ms}) begin
            fires = 16'd1;
            return btnlp_pkg::EV_LONG;
         end
      end else begin
         since = now - (hold_start_ms + {16'd0, long_ms});
         // a zero interval divides to all ones
         quot  = (rep_ms == '0) ? '1 : since / {16'd0, rep_ms};
         total = quot + 32'd1;
         want  = total[btnlp_pkg::CountWidth-1:0];
         if (fires < want) begin
            fires = fires + 16'd1;
            return btnlp_pkg::EV_REPEAT;
         end
      end
      return btnlp_pkg::EV_NONE;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      err_count++;
   endtask

   // monitor: predictor update, event check and watchdog
   always @(posedge clock) begin
      if (reset) begin
         key_held      = 1'b0;
         hold_start_ms = '0;
         fires         = '0;
         long_ms       = btnlp_pkg::LongPressReset;
         rep_ms        = btnlp_pkg::RepeatReset;
         req_taken    <= 1'b0;
         quiet_cycles  = 0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               btnlp_pkg::RegLongPress: long_ms = csr_if.data;
               btnlp_pkg::RegRepeat:    rep_ms  = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            event_q.push_back(predict_event(req_if.pressed, req_if.now_ms));
         if (rsp_if.valid && rsp_if.ready) begin
            if (event_q.size() == 0) begin
               report_mismatch($sformatf("event %0d with none predicted",
                                         rsp_if.event_res));
            end else if (rsp_if.event_res !== event_q[0]) begin
               report_mismatch($sformatf("event_res %0d, predicted %0d",
                                         rsp_if.event_res, event_q[0]));
               void'(event_q.pop_front());
            end else begin
               void'(event_q.pop_front());
            end
         end
         // watchdog on cycles with no handshake at all
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("watchdog: no handshake for %0d cycles", QuietLimit);
            $display("[button_click_longpress_repeat_unit] ERROR");
            $finish;
         end
      end
   end

   // sample driver with random idle bursts
   always @(negedge clock) begin
      key_sample_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (sample_q.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(0, 2);
            req_if.valid <= 1'b0;
         end else begin
            nxt = sample_q.pop_front();
            req_if.valid   <= 1'b1;
            req_if.pressed <= nxt.pressed;
            req_if.now_ms  <= nxt.now_ms;
         end
      end
   end

   // event sink with random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_gap = $urandom_range(0, 2);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic queue_sample(input logic key,
                               input logic [btnlp_pkg::TimeWidth-1:0] now);
      key_sample_type s;
      s.pressed = key;
      s.now_ms  = now;
      sample_q.push_back(s);
      phase_count++;
   endtask

   task automatic write_reg(input logic [btnlp_pkg::CsrIndexWidth-1:0] idx,
                            input logic [btnlp_pkg::CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // wait until every sample is taken and every event has come back
   task automatic drain();
      @(negedge clock);
      while (sample_q.size() != 0 || req_if.valid || event_q.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic set_delays(input int unsigned lp, input int unsigned rp);
      drain();
      write_reg(btnlp_pkg::RegLongPress, lp[btnlp_pkg::CsrDataWidth-1:0]);
      write_reg(btnlp_pkg::RegRepeat, rp[btnlp_pkg::CsrDataWidth-1:0]);
      gen_long = lp;
      gen_rep  = rp;
   endtask

   // one hold: press, a few held samples, usually a release
   task automatic queue_hold();
      int                              n;
      logic [btnlp_pkg::TimeWidth-1:0] step;
      if ($urandom_range(0, 7) == 0) tick_ms = $urandom();
      else                           tick_ms = tick_ms + $urandom_range(1, 1000);
      queue_sample(1'b1, tick_ms);
      n = $urandom_range(0, 10);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0:       step = $urandom();
            1, 2:    step = $urandom_range(0, gen_long / 2 + 1);
            3, 4, 5: step = $urandom_range(0, 2 * gen_rep + 1);
            default: step = $urandom_range(0, gen_long + 2 * gen_rep);
         endcase
         tick_ms = tick_ms + step;
         queue_sample(1'b1, tick_ms);
      end
      // leave some holds open so the next press lands on a held key
      if ($urandom_range(0, 9) != 0) begin
         tick_ms = tick_ms + $urandom_range(0, gen_long + gen_rep);
         queue_sample(1'b0, tick_ms);
      end
   endtask

   task automatic run_random_phase();
      phase_count = 0;
      while (phase_count < PhaseItems) begin
         if ($urandom_range(0, 9) == 0)
            queue_sample(1'($urandom_range(0, 1)), $urandom());
         else
            queue_hold();
      end
   endtask

   // stimulus and end of run
   initial begin
      req_if.valid   = 1'b0;
      req_if.pressed = 1'b0;
      req_if.now_ms  = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      err_count      = 0;
      idle_on        = 1'b1;
      tick_ms        = '0;
      gen_long       = btnlp_pkg::LongPressReset;
      gen_rep        = btnlp_pkg::RepeatReset;
      reset          = 1'b1;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset delays: idle release, click, long press and repeats, time wrap
      queue_sample(1'b0, 32'd0);
      queue_sample(1'b1, 32'd1000);
      queue_sample(1'b0, 32'd1100);
      queue_sample(1'b1, 32'd2000);
      queue_sample(1'b1, 32'd2499);
      queue_sample(1'b1, 32'd2500);
      queue_sample(1'b1, 32'd2750);
      queue_sample(1'b1, 32'd2750);
      queue_sample(1'b1, 32'd4000);
      queue_sample(1'b0, 32'd4100);
      queue_sample(1'b1, 32'hFFFF_FF00);
      queue_sample(1'b1, 32'h0000_00F4);
      queue_sample(1'b0, 32'hFFFF_FFFF);
      // timestamp going backwards reads as a long hold
      queue_sample(1'b1, 32'd5000);
      queue_sample(1'b1, 32'd4999);
      queue_sample(1'b1, 32'd4998);
      queue_sample(1'b0, 32'd0);

      // zero delays: long press on the second held sample, no repeats
      set_delays(0, 0);
      write_reg(RegUnused, 16'd1234);
      queue_sample(1'b1, 32'd100);
      queue_sample(1'b1, 32'd100);
      queue_sample(1'b1, 32'h7FFF_FFFF);
      queue_sample(1'b0, 32'd200);

      // random phases over a spread of delay settings
      set_delays(1, 1);
      run_random_phase();
      set_delays(65535, 65535);
      run_random_phase();
      set_delays($urandom_range(1, 50), $urandom_range(1, 20));
      run_random_phase();
      set_delays($urandom_range(1, 65535), $urandom_range(1, 65535));
      run_random_phase();
      set_delays(65535, 1);
      write_reg(RegUnused, 16'hFFFF);
      run_random_phase();
      set_delays($urandom_range(1, 2000), $urandom_range(1, 1000));
      idle_on = 1'b0;
      run_random_phase();

      drain();
      if (err_count == 0)
         $display("[button_click_longpress_repeat_unit] OK");
      else
         $display("[button_click_longpress_repeat_unit] ERROR");
      $finish;
   end

endmodule
